/* sv/frame_quality_warning_detector_defines.svh */
// Assertion macros used by the frame quality warning detector datapath.
`ifndef FRAME_QUALITY_WARNING_DETECTOR_DEFINES_SVH
`define FRAME_QUALITY_WARNING_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on a named clock, held off while the named reset is high.
`define FQWD_ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// Same check on the local clk and rst.
`define FQWD_ASSERT(lbl, prop, msg) \
  `FQWD_ASSERT_CLK(lbl, clk, rst, prop, msg)
`else
`define FQWD_ASSERT_CLK(lbl, ck, rs, prop, msg)
`define FQWD_ASSERT(lbl, prop, msg)
`endif

`endif

/* sv/fqwd_pkg.sv */
`timescale 1ns / 1ps
// Types, constants and codes shared by the frame quality warning detector.
package fqwd_pkg;

  // Default parameter values
  localparam int COUNT_BITS_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // Item field widths
  localparam int STAR_W  = 16;
  localparam int BG_W    = 16;
  localparam int WIDTH_W = 12;
  localparam int CENT_W  = 16;

  // Configuration register widths and reset values
  localparam int RATIO_W = 10;
  localparam int LIMIT_W = 12;
  localparam int DROP_W  = 8;
  localparam int RISE_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [RATIO_W-1:0] RATIO_HIGH_RST = 10'd358;
  localparam logic [RATIO_W-1:0] RATIO_LOW_RST  = 10'd179;
  localparam logic [LIMIT_W-1:0] SHIFT_LIMIT_RST = 12'd80;
  localparam logic [DROP_W-1:0]  DROP_RST        = 8'd102;
  localparam logic [RISE_W-1:0]  RISE_RST        = 16'd100;

  // Ratio of 1.0 in 8 fraction bits, used when width_y is zero
  localparam logic [WIDTH_W+7:0] RATIO_ONE_Q8 = 20'd256;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATIO_HIGH  = 3'd0,
    CFG_RATIO_LOW   = 3'd1,
    CFG_SHIFT_LIMIT = 3'd2,
    CFG_DROP        = 3'd3,
    CFG_RISE        = 3'd4
  } cfg_idx_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RHI,
    ST_RLO,
    ST_NCX,
    ST_NCY,
    ST_DXSQ,
    ST_DYSQ,
    ST_LIMN,
    ST_LIMSQ,
    ST_NSTAR,
    ST_DROP,
    ST_NBG,
    ST_RISE,
    ST_FINISH
  } state_t;

  // Datapath step codes
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RHI,
    OP_RLO,
    OP_NCX,
    OP_NCY,
    OP_DXSQ,
    OP_DYSQ,
    OP_LIMN,
    OP_LIMSQ,
    OP_NSTAR,
    OP_DROP,
    OP_NBG,
    OP_RISE,
    OP_FINISH
  } op_t;

  // Controller to datapath
  typedef struct packed {
    op_t  op;
    logic load;    // capture item, clear history on start of sequence
    logic finish;  // write result register and accumulate
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_zero;    // no earlier frames in this sequence
    logic out_busy;  // result register holds an item not taken this cycle
  } dp_status_t;

endpackage

/* sv/fqwd_ctrl.sv */
`timescale 1ns / 1ps
// Sequencing state machine of the frame quality warning detector.
module fqwd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fqwd_pkg::dp_status_t status,
  output fqwd_pkg::dp_cmd_t   cmd
);
  import fqwd_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_RHI;
      end
      ST_RHI: begin
        // first frame of a sequence: nothing to check
        state_next = status.n_zero ? ST_FINISH : ST_RLO;
      end
      ST_RLO:   state_next = ST_NCX;
      ST_NCX:   state_next = ST_NCY;
      ST_NCY:   state_next = ST_DXSQ;
      ST_DXSQ:  state_next = ST_DYSQ;
      ST_DYSQ:  state_next = ST_LIMN;
      ST_LIMN:  state_next = ST_LIMSQ;
      ST_LIMSQ: state_next = ST_NSTAR;
      ST_NSTAR: state_next = ST_DROP;
      ST_DROP:  state_next = ST_NBG;
      ST_NBG:   state_next = ST_RISE;
      ST_RISE:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs; nothing is taken while reset is high
  always_comb begin
    in_ready   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.load   = 1'b0;
    cmd.finish = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_RHI:   cmd.op = OP_RHI;
      ST_RLO:   cmd.op = OP_RLO;
      ST_NCX:   cmd.op = OP_NCX;
      ST_NCY:   cmd.op = OP_NCY;
      ST_DXSQ:  cmd.op = OP_DXSQ;
      ST_DYSQ:  cmd.op = OP_DYSQ;
      ST_LIMN:  cmd.op = OP_LIMN;
      ST_LIMSQ: cmd.op = OP_LIMSQ;
      ST_NSTAR: cmd.op = OP_NSTAR;
      ST_DROP:  cmd.op = OP_DROP;
      ST_NBG:   cmd.op = OP_NBG;
      ST_RISE:  cmd.op = OP_RISE;
      ST_FINISH: begin
        cmd.op     = OP_FINISH;
        cmd.finish = !status.out_busy;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

/* sv/fqwd_datapath.sv */
`timescale 1ns / 1ps
// Running sums, shared multiplier and flag logic of the frame quality detector.
`include "frame_quality_warning_detector_defines.svh"
module fqwd_datapath #(
  parameter int COUNT_BITS  = fqwd_pkg::COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = fqwd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fqwd_pkg::dp_cmd_t                 cmd,
  output fqwd_pkg::dp_status_t              status,
  input  logic                              start_sequence,
  input  logic [fqwd_pkg::STAR_W-1:0]       num_stars,
  input  logic [fqwd_pkg::BG_W-1:0]         sky_background,
  input  logic [fqwd_pkg::WIDTH_W-1:0]      width_x,
  input  logic [fqwd_pkg::WIDTH_W-1:0]      width_y,
  input  logic [fqwd_pkg::CENT_W-1:0]       centroid_x,
  input  logic [fqwd_pkg::CENT_W-1:0]       centroid_y,
  input  logic [fqwd_pkg::RATIO_W-1:0]      ratio_high_q8,
  input  logic [fqwd_pkg::RATIO_W-1:0]      ratio_low_q8,
  input  logic [fqwd_pkg::LIMIT_W-1:0]      shift_limit_sixteenths,
  input  logic [fqwd_pkg::DROP_W-1:0]       drop_fraction_q8,
  input  logic [fqwd_pkg::RISE_W-1:0]       background_rise_limit,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              baseline_ready,
  output logic                              wind_flag,
  output logic                              cloud
);
  import fqwd_pkg::*;

  localparam int SUM_W  = COUNT_BITS + SAMPLE_BITS;
  // n times a 16 bit sample must fit one multiplier operand
  localparam int MUL_W  = (SUM_W > COUNT_BITS + CENT_W) ? SUM_W : COUNT_BITS + CENT_W;
  localparam int PROD_W = 2 * MUL_W;

  // Captured item
  logic [STAR_W-1:0]  stars_r;
  logic [BG_W-1:0]    bg_r;
  logic [WIDTH_W-1:0] wx_r;
  logic [WIDTH_W-1:0] wy_r;
  logic [CENT_W-1:0]  cx_r;
  logic [CENT_W-1:0]  cy_r;

  // History
  logic [SUM_W-1:0]      star_sum;
  logic [SUM_W-1:0]      background_sum;
  logic [SUM_W-1:0]      centroid_x_sum;
  logic [SUM_W-1:0]      centroid_y_sum;
  logic [COUNT_BITS-1:0] frame_count;

  // Working registers
  logic [PROD_W-1:0] prod;
  logic [MUL_W-1:0]  dx;
  logic [MUL_W-1:0]  dy;
  logic [PROD_W:0]   acc;
  logic              lt;
  logic              wind_r;
  logic              cloud_r;

  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic                 mul_load;
  logic [WIDTH_W+7:0]   ratio_num;
  logic [WIDTH_W-1:0]   ratio_den;
  logic [MUL_W-1:0]     n_m;
  logic [MUL_W-1:0]     prod_lo;
  logic [MUL_W-1:0]     diff_src;
  logic [MUL_W-1:0]     abs_diff;
  logic [PROD_W-1:0]    bg_bound;
  logic                 bg_hit;
  logic                 count_full;

  // Ratio operands; a zero width_y counts as a ratio of exactly one
  assign ratio_num = (wy_r != '0) ? {wx_r, 8'h00} : RATIO_ONE_Q8;
  assign ratio_den = (wy_r != '0) ? wy_r : WIDTH_W'(1);

  assign n_m     = MUL_W'(frame_count);
  assign prod_lo = prod[MUL_W-1:0];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_RHI: begin
        mul_a = MUL_W'(ratio_high_q8);
        mul_b = MUL_W'(ratio_den);
      end
      OP_RLO: begin
        mul_a = MUL_W'(ratio_low_q8);
        mul_b = MUL_W'(ratio_den);
      end
      OP_NCX: begin
        mul_a = n_m;
        mul_b = MUL_W'(cx_r);
      end
      OP_NCY: begin
        mul_a = n_m;
        mul_b = MUL_W'(cy_r);
      end
      OP_DXSQ: begin
        mul_a = dx;
        mul_b = dx;
      end
      OP_DYSQ: begin
        mul_a = dy;
        mul_b = dy;
      end
      OP_LIMN: begin
        mul_a = MUL_W'(shift_limit_sixteenths);
        mul_b = n_m;
      end
      OP_LIMSQ: begin
        mul_a = prod_lo;
        mul_b = prod_lo;
      end
      OP_NSTAR: begin
        mul_a = n_m;
        mul_b = MUL_W'(stars_r);
      end
      OP_DROP: begin
        mul_a = MUL_W'(drop_fraction_q8);
        mul_b = MUL_W'(star_sum);
      end
      OP_NBG: begin
        mul_a = n_m;
        mul_b = MUL_W'(bg_r);
      end
      OP_RISE: begin
        mul_a = MUL_W'(background_rise_limit);
        mul_b = n_m;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign mul_load = !(cmd.op == OP_NONE || cmd.op == OP_FINISH);

  // Centroid distance from baseline, as |n*c - S|
  assign diff_src = (cmd.op == OP_NCY) ? MUL_W'(centroid_x_sum) : MUL_W'(centroid_y_sum);
  assign abs_diff = (prod_lo >= diff_src) ? prod_lo - diff_src : diff_src - prod_lo;

  // Background test: n*bg against sum + rise*n
  assign bg_bound = PROD_W'(background_sum) + prod;
  assign bg_hit   = PROD_W'(dy) > bg_bound;

  assign count_full = (frame_count == {COUNT_BITS{1'b1}});

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stars_r <= num_stars;
      bg_r    <= sky_background;
      wx_r    <= width_x;
      wy_r    <= width_y;
      cx_r    <= centroid_x;
      cy_r    <= centroid_y;
    end
  end

  // History: cleared on reset and on start of sequence, grown when the item finishes unless the count is full
  always_ff @(posedge clk) begin
    if (rst) begin
      star_sum       <= '0;
      background_sum <= '0;
      centroid_x_sum <= '0;
      centroid_y_sum <= '0;
      frame_count    <= '0;
    end else if (cmd.load && start_sequence) begin
      star_sum       <= '0;
      background_sum <= '0;
      centroid_x_sum <= '0;
      centroid_y_sum <= '0;
      frame_count    <= '0;
    end else if (cmd.finish && !count_full) begin
      star_sum       <= star_sum + SUM_W'(stars_r);
      background_sum <= background_sum + SUM_W'(bg_r);
      centroid_x_sum <= centroid_x_sum + SUM_W'(cx_r);
      centroid_y_sum <= centroid_y_sum + SUM_W'(cy_r);
      frame_count    <= frame_count + COUNT_BITS'(1);
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (mul_load) prod <= mul_p;
  end

  // Step work on the previous product
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_NCY:   dx  <= abs_diff;
      OP_DXSQ:  dy  <= abs_diff;
      OP_DYSQ:  acc <= {1'b0, prod};
      OP_LIMN:  acc <= acc + {1'b0, prod};
      OP_DROP: begin
        lt <= prod < PROD_W'(star_sum);
        dx <= MUL_W'(star_sum) - prod_lo;
      end
      OP_RISE:  dy  <= prod_lo;
      default: begin
      end
    endcase
  end

  // Flags
  always_ff @(posedge clk) begin
    if (rst) begin
      wind_r  <= 1'b0;
      cloud_r <= 1'b0;
    end else if (cmd.load) begin
      wind_r  <= 1'b0;
      cloud_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_RLO:   wind_r <= wind_r | (PROD_W'(ratio_num) > prod);
        OP_NCX:   wind_r <= wind_r | (PROD_W'(ratio_num) < prod);
        OP_NSTAR: wind_r <= wind_r | (acc > {1'b0, prod});
        OP_NBG:   cloud_r <= cloud_r | (lt && (PROD_W'({dx, 8'h00}) > prod));
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      baseline_ready <= !status.n_zero;
      wind_flag      <= wind_r && !status.n_zero;
      cloud          <= (cloud_r || bg_hit) && !status.n_zero;
    end
  end

  assign status.n_zero   = (frame_count == '0);
  assign status.out_busy = out_valid && !out_ready;

  `FQWD_ASSERT(a_first_quiet, out_valid && !baseline_ready |-> !wind_flag && !cloud, "flag without baseline")
  `FQWD_ASSERT(a_count_grows, !cmd.load |=> frame_count >= $past(frame_count), "frame count fell")
  `FQWD_ASSERT(a_start_clears, cmd.load && start_sequence |=> frame_count == '0, "history not cleared")
  `FQWD_ASSERT(a_finish_shows, cmd.finish |=> out_valid, "result not shown")

endmodule

/* sv/frame_quality_warning_detector.sv */
`timescale 1ns / 1ps
// Top level of the frame quality warning detector.
//
//  channel  direction  handshake              payload
//  in       to block   in_valid / in_ready    start_sequence .. centroid_y
//  out      from block out_valid / out_ready  baseline_ready, wind_flag, cloud
//  cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A checked frame passes from accept through twelve steps on the single shared
// multiplier to a finish step. The first frame of a sequence skips the checks and
// goes from the first ratio step straight to finish. The next item is accepted in the
// cycle after the result register loads; a stalled result holds only the finish step.
// Reset clears the history and restores the register defaults; in_ready and cfg_ready
// stay low while reset is high, and cfg_ready is high otherwise.
module frame_quality_warning_detector #(
  parameter int COUNT_BITS  = fqwd_pkg::COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = fqwd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              start_sequence,
  input  logic [fqwd_pkg::STAR_W-1:0]       num_stars,
  input  logic [fqwd_pkg::BG_W-1:0]         sky_background,
  input  logic [fqwd_pkg::WIDTH_W-1:0]      width_x,
  input  logic [fqwd_pkg::WIDTH_W-1:0]      width_y,
  input  logic [fqwd_pkg::CENT_W-1:0]       centroid_x,
  input  logic [fqwd_pkg::CENT_W-1:0]       centroid_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              baseline_ready,
  output logic                              wind_flag,
  output logic                              cloud,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fqwd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fqwd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fqwd_pkg::*;

  logic [RATIO_W-1:0] ratio_high_q8;
  logic [RATIO_W-1:0] ratio_low_q8;
  logic [LIMIT_W-1:0] shift_limit_sixteenths;
  logic [DROP_W-1:0]  drop_fraction_q8;
  logic [RISE_W-1:0]  background_rise_limit;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = !rst;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_high_q8          <= RATIO_HIGH_RST;
      ratio_low_q8           <= RATIO_LOW_RST;
      shift_limit_sixteenths <= SHIFT_LIMIT_RST;
      drop_fraction_q8       <= DROP_RST;
      background_rise_limit  <= RISE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RATIO_HIGH:  ratio_high_q8          <= cfg_data[RATIO_W-1:0];
        CFG_RATIO_LOW:   ratio_low_q8           <= cfg_data[RATIO_W-1:0];
        CFG_SHIFT_LIMIT: shift_limit_sixteenths <= cfg_data[LIMIT_W-1:0];
        CFG_DROP:        drop_fraction_q8       <= cfg_data[DROP_W-1:0];
        CFG_RISE:        background_rise_limit  <= cfg_data[RISE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  fqwd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Sums, multiplier and flags
  fqwd_datapath #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .status                 (status),
    .start_sequence         (start_sequence),
    .num_stars              (num_stars),
    .sky_background         (sky_background),
    .width_x                (width_x),
    .width_y                (width_y),
    .centroid_x             (centroid_x),
    .centroid_y             (centroid_y),
    .ratio_high_q8          (ratio_high_q8),
    .ratio_low_q8           (ratio_low_q8),
    .shift_limit_sixteenths (shift_limit_sixteenths),
    .drop_fraction_q8       (drop_fraction_q8),
    .background_rise_limit  (background_rise_limit),
    .out_ready              (out_ready),
    .out_valid              (out_valid),
    .baseline_ready         (baseline_ready),
    .wind_flag              (wind_flag),
    .cloud                  (cloud)
  );

endmodule
